// ===== rtl/rrep_pkg.sv =====
// Shared types and constants for the ray / rectangle exit point core.
package rrep_pkg;

  localparam int CoordW  = 32;   // Q16.16 coordinate width
  localparam int DiffW   = 33;   // difference of two coordinates
  localparam int ProdW   = 66;   // exact product of two differences
  localparam int QuoW    = 41;   // quotient bits kept; larger means overflow
  localparam int SumW    = 43;   // base +/- quotient before saturation
  localparam int DivSteps = QuoW;

  // One divider slot: restoring long division, one quotient bit a stage.
  typedef struct packed {
    logic [DiffW-1:0]  rem;      // partial remainder, below den unless ovf or zero is set
    logic [QuoW-1:0]   num;      // numerator bits not yet brought down
    logic [QuoW-1:0]   quo;      // quotient bits so far
    logic [DiffW-1:0]  den;      // divisor magnitude
    logic              neg;      // quotient is subtracted from base
    logic [CoordW-1:0] base;     // start coordinate on the solved axis
    logic [CoordW-1:0] edge_v;   // fixed coordinate of the chosen edge
    logic              vert;     // exit on a vertical edge
    logic              ovf;      // quotient already known to be too big
    logic              zero;     // divisor was zero
  } div_t;

endpackage

// ===== rtl/rrep_div_stage.sv =====
// One restoring-division stage: brings down one numerator bit, makes one quotient bit.
module rrep_div_stage
  import rrep_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_ready,
  input  div_t up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output div_t dn_data
);

  logic [DiffW:0]   trial;
  logic             ge;
  logic [DiffW:0]   diff;
  div_t             data_next;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    trial = {up_data.rem, up_data.num[QuoW-1]};
    ge    = trial >= {1'b0, up_data.den};
    diff  = trial - {1'b0, up_data.den};
    data_next      = up_data;
    data_next.rem  = ge ? diff[DiffW-1:0] : trial[DiffW-1:0];
    data_next.num  = {up_data.num[QuoW-2:0], 1'b0};
    data_next.quo  = {up_data.quo[QuoW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= data_next;
    end
  end

endmodule

// ===== rtl/ray_rectangle_exit_point_core.sv =====
// Top level: ray / rectangle exit point, fully pipelined with a bit-per-stage divider.
//
//  channel  | dir | tdata (low bit up)                                   | tuser
//  s_axis   | in  | start_x, start_y, toward_x, toward_y,                | -
//           |     | rect_min_x, rect_min_y, rect_max_x, rect_max_y       |
//  m_axis   | out | hit_x, hit_y                                         | hit_vertical_edge,
//           |     |                                                      | degenerate
//
// One beat in and one beat out per cycle, sustained while m_axis_tready stays high.
// The pipeline has four stages of setup (differences, two 33x33 products, cross
// sign and magnitudes, edge select), 41 divider stages of one quotient bit each,
// and the saturating add into the output register.
// Every stage holds its own valid bit and loads when it is empty or its
// successor loads, so bubbles close up and a stall drops or repeats nothing.
// Synchronous reset clears only the valid bits.
module ray_rectangle_exit_point_core
  import rrep_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // start_x, start_y, toward_x, toward_y, rect_min_x, rect_min_y, rect_max_x, rect_max_y
  input  logic [255:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit_x, hit_y
  output logic [63:0]  m_axis_tdata,
  // hit_vertical_edge, degenerate
  output logic [1:0]   m_axis_tuser
);

  // ---------------- stage 1: differences and quadrant corner
  logic                     v1, r1;
  logic signed [DiffW-1:0]  ax1, ay1, dx1, dy1, ex1, ey1;
  logic signed [CoordW-1:0] cx1, cy1;

  logic signed [DiffW-1:0]  in_ax, in_ay, in_dx, in_dy;
  logic signed [CoordW-1:0] in_cx, in_cy;

  always_comb begin
    in_ax = DiffW'($signed(s_axis_tdata[31:0]));
    in_ay = DiffW'($signed(s_axis_tdata[63:32]));
    in_dx = DiffW'($signed(s_axis_tdata[95:64])) - in_ax;
    in_dy = DiffW'($signed(s_axis_tdata[127:96])) - in_ay;
    // a zero component counts as non-negative
    in_cx = in_dx[DiffW-1] ? $signed(s_axis_tdata[159:128]) : $signed(s_axis_tdata[223:192]);
    in_cy = in_dy[DiffW-1] ? $signed(s_axis_tdata[191:160]) : $signed(s_axis_tdata[255:224]);
  end

  // ---------------- stage 2: the two cross-product terms
  logic                     v2, r2;
  logic signed [ProdW-1:0]  p2, q2;      // p = dx*ey, q = dy*ex
  logic signed [DiffW-1:0]  dx2, dy2;
  logic [CoordW-1:0]        ax2, ay2, cx2, cy2;

  // ---------------- stage 3: cross sign and product magnitudes
  logic                     v3, r3;
  logic                     cr_pos3, cr_neg3;
  logic [ProdW-1:0]         pm3, qm3;
  logic                     ps3, qs3;
  logic signed [DiffW-1:0]  dx3, dy3;
  logic [CoordW-1:0]        ax3, ay3, cx3, cy3;

  // ---------------- stage 4: edge choice, divider setup
  logic                     v4, r4;
  div_t                     d4;

  assign s_axis_tready = r1;
  assign r1 = !v1 || r2;
  assign r2 = !v2 || r3;
  assign r3 = !v3 || r4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= s_axis_tvalid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && s_axis_tvalid) begin
      ax1 <= in_ax;
      ay1 <= in_ay;
      dx1 <= in_dx;
      dy1 <= in_dy;
      cx1 <= in_cx;
      cy1 <= in_cy;
      ex1 <= DiffW'(in_cx) - in_ax;
      ey1 <= DiffW'(in_cy) - in_ay;
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      p2  <= ProdW'(dx1) * ProdW'(ey1);
      q2  <= ProdW'(dy1) * ProdW'(ex1);
      dx2 <= dx1;
      dy2 <= dy1;
      ax2 <= ax1[CoordW-1:0];
      ay2 <= ay1[CoordW-1:0];
      cx2 <= cx1;
      cy2 <= cy1;
    end
  end

  logic signed [ProdW:0] cross2;
  assign cross2 = (ProdW+1)'(p2) - (ProdW+1)'(q2);

  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      cr_neg3 <= cross2[ProdW];
      cr_pos3 <= !cross2[ProdW] && (cross2 != '0);
      pm3     <= p2[ProdW-1] ? ProdW'(-p2) : p2;
      qm3     <= q2[ProdW-1] ? ProdW'(-q2) : q2;
      ps3     <= p2[ProdW-1];
      qs3     <= q2[ProdW-1];
      dx3     <= dx2;
      dy3     <= dy2;
      ax3     <= ax2;
      ay3     <= ay2;
      cx3     <= cx2;
      cy3     <= cy2;
    end
  end

  // Vertical edge: solve y from n = |dy*ex|, den = dx.
  // Horizontal edge: solve x from n = |dx*ey|, den = dy.
  logic                    vert3;
  logic [ProdW-1:0]        n3;
  logic signed [DiffW-1:0] den3;
  logic [DiffW-1:0]        dmag3;
  div_t                    d4_next;

  always_comb begin
    vert3 = (dx3[DiffW-1] == dy3[DiffW-1]) ? cr_pos3 : cr_neg3;
    n3    = vert3 ? qm3 : pm3;
    den3  = vert3 ? dx3 : dy3;
    dmag3 = den3[DiffW-1] ? DiffW'(-den3) : den3;
    d4_next.rem    = DiffW'(n3[ProdW-1:QuoW]);
    d4_next.num    = n3[QuoW-1:0];
    d4_next.quo    = '0;
    d4_next.den    = dmag3;
    d4_next.neg    = (vert3 ? qs3 : ps3) ^ den3[DiffW-1];
    d4_next.base   = vert3 ? ay3 : ax3;
    d4_next.edge_v = vert3 ? cx3 : cy3;
    d4_next.vert   = vert3;
    // quotient fits QuoW bits only if the bits above them are below den
    d4_next.ovf    = DiffW'(n3[ProdW-1:QuoW]) >= dmag3;
    d4_next.zero   = (den3 == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (r4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r4 && v3) begin
      d4 <= d4_next;
    end
  end

  // ---------------- divider chain
  logic [DivSteps:0] dv, dr;
  div_t              dd [DivSteps+1];

  assign dv[0] = v4;
  assign dd[0] = d4;
  assign r4    = dr[0];

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    rrep_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (dv[k]),
      .up_ready (dr[k]),
      .up_data  (dd[k]),
      .dn_valid (dv[k+1]),
      .dn_ready (dr[k+1]),
      .dn_data  (dd[k+1])
    );
  end

  // ---------------- final: sign, add, saturate, output register
  div_t                  df;
  logic                  big_f;
  logic signed [SumW-1:0] sum_f;
  logic [CoordW-1:0]     solved_f;
  logic                  deg_f;

  localparam logic signed [SumW-1:0] SatMax = SumW'(32'sh7fffffff);
  localparam logic signed [SumW-1:0] SatMin = -SumW'(64'sh80000000);

  always_comb begin
    df    = dd[DivSteps];
    // largest allowed quotient is 2^40
    big_f = df.ovf || (df.quo[QuoW-1] && (df.quo[QuoW-2:0] != '0));
    sum_f = df.neg ? SumW'($signed(df.base)) - $signed(SumW'(df.quo))
                   : SumW'($signed(df.base)) + $signed(SumW'(df.quo));
    deg_f = 1'b0;
    if (df.zero) begin
      solved_f = df.base;
      deg_f    = 1'b1;
    end else if (big_f) begin
      solved_f = df.neg ? 32'h80000000 : 32'h7fffffff;
      deg_f    = 1'b1;
    end else if (sum_f > SatMax) begin
      solved_f = 32'h7fffffff;
      deg_f    = 1'b1;
    end else if (sum_f < SatMin) begin
      solved_f = 32'h80000000;
      deg_f    = 1'b1;
    end else begin
      solved_f = sum_f[CoordW-1:0];
    end
  end

  assign dr[DivSteps] = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (dr[DivSteps]) begin
      m_axis_tvalid <= dv[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (dr[DivSteps] && dv[DivSteps]) begin
      m_axis_tdata[31:0]  <= df.vert ? df.edge_v : solved_f;
      m_axis_tdata[63:32] <= df.vert ? solved_f : df.edge_v;
      m_axis_tuser        <= {deg_f, df.vert};
    end
  end

  // ---------------- checks
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid && !v1 && !v4)
    else $error("pipeline not empty after reset");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> v1)
    else $error("accepted beat did not reach stage 1");

  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !r2 |=> v1 && $stable(dx1) && $stable(dy1))
    else $error("stalled stage 1 lost its item");

  a_zero_deg: assert property (@(posedge clk) disable iff (rst)
    dv[DivSteps] && dr[DivSteps] && df.zero |=> m_axis_tuser[1])
    else $error("zero divisor not flagged");

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the ray / rectangle exit point core: random and corner rays, self-checking.
`timescale 1ns / 1ps

module tb_top;
  import rrep_pkg::*;

  typedef struct {
    logic signed [31:0] sx, sy, tx, ty, mnx, mny, mxx, mxy;
  } ray_query_t;

  typedef struct {
    logic [31:0] hx, hy;
    logic        vert, deg;
  } exit_point_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  ray_rectangle_exit_point_core uut (.*);

  always #5 clk = ~clk;

  ray_query_t  pending_q[$];
  exit_point_t exit_q[$];
  int          mismatches = 0;
  bit          calm = 1'b0;      // no idling on either side
  bit          hold_off = 1'b0;  // receiver long stall request
  bit          src_pause = 1'b0;

  // Exact signed integer arithmetic on wide vectors.
  function automatic logic [31:0] solve_coord(logic signed [33:0] m1, logic signed [33:0] m2,
                                              logic signed [33:0] den, logic signed [31:0] base,
                                              ref logic deg);
    logic signed [67:0]  num;
    logic signed [67:0]  quo;
    logic signed [69:0]  sum;
    if (den == 0) begin
      deg = 1'b1;
      return base;
    end
    num = 68'(m1) * 68'(m2);
    quo = num / 68'(den);  // truncates toward zero
    sum = 70'(base) + 70'(quo);
    if (sum > 70'sd2147483647) begin
      deg = 1'b1;
      return 32'h7fffffff;
    end
    if (sum < -70'sd2147483648) begin
      deg = 1'b1;
      return 32'h80000000;
    end
    return sum[31:0];
  endfunction

  function automatic exit_point_t predict_exit(ray_query_t q);
    exit_point_t        r;
    logic signed [33:0] ax, ay, dx, dy, cx, cy;
    logic signed [69:0] cr;
    logic               d;
    ax = q.sx; ay = q.sy;
    dx = 34'(q.tx) - ax;
    dy = 34'(q.ty) - ay;
    cx = dx < 0 ? 34'(q.mnx) : 34'(q.mxx);
    cy = dy < 0 ? 34'(q.mny) : 34'(q.mxy);
    cr = 70'(dx) * 70'(cy - ay) - 70'(dy) * 70'(cx - ax);
    // same quadrant signs: vertical on positive cross, otherwise on negative
    if ((dx < 0) == (dy < 0)) r.vert = cr > 0;
    else r.vert = cr < 0;
    d = 1'b0;
    if (r.vert) begin
      r.hx = cx[31:0];
      r.hy = solve_coord(cx - ax, dy, dx, q.sy, d);
    end else begin
      r.hy = cy[31:0];
      r.hx = solve_coord(cy - ay, dx, dy, q.sx, d);
    end
    r.deg = d;
    return r;
  endfunction

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 9))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'(32'($urandom_range(0, 20)) - 10);
      3, 4, 5: return 32'(int'($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic ray_query_t rnd_query();
    ray_query_t q;
    q.sx = rnd_coord(); q.sy = rnd_coord();
    q.mnx = rnd_coord(); q.mny = rnd_coord();
    if ($urandom_range(0, 3) != 0) begin
      // well-formed: ordered box with start inside
      q.mnx = 32'(int'($urandom_range(0, 4000000)) - 2000000);
      q.mny = 32'(int'($urandom_range(0, 4000000)) - 2000000);
      q.mxx = q.mnx + 32'($urandom_range(0, 3000000));
      q.mxy = q.mny + 32'($urandom_range(0, 3000000));
      q.sx = q.mnx + 32'($urandom_range(0, q.mxx - q.mnx));
      q.sy = q.mny + 32'($urandom_range(0, q.mxy - q.mny));
      q.tx = q.sx + 32'(int'($urandom_range(0, 200000)) - 100000);
      q.ty = q.sy + 32'(int'($urandom_range(0, 200000)) - 100000);
      if ($urandom_range(0, 7) == 0) q.tx = q.sx;
      if ($urandom_range(0, 7) == 0) q.ty = q.sy;
    end else begin
      q.mxx = rnd_coord(); q.mxy = rnd_coord();
      q.tx = rnd_coord(); q.ty = rnd_coord();
    end
    return q;
  endfunction

  function automatic ray_query_t mk(int sx, int sy, int tx, int ty, int a, int b, int c, int d);
    ray_query_t q;
    q.sx = sx; q.sy = sy; q.tx = tx; q.ty = ty;
    q.mnx = a; q.mny = b; q.mxx = c; q.mxy = d;
    return q;
  endfunction

  // Driver: next beat offered once the current one is taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() > 0 && !src_pause && (calm || $urandom_range(0, 99) >= 17)) begin
          ray_query_t q;
          q = pending_q.pop_front();
          exit_q.push_back(predict_exit(q));
          s_axis_tdata <= {q.mxy, q.mxx, q.mny, q.mnx, q.ty, q.tx, q.sy, q.sx};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready, with a long hold-off when requested.
  always @(posedge clk) begin
    if (!rst)
      m_axis_tready <= !hold_off && (calm || $urandom_range(0, 99) >= 17);
  end

  // Monitor and checker.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (exit_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h %b", m_axis_tdata, m_axis_tuser);
      end else begin
        exit_point_t e;
        e = exit_q.pop_front();
        if (m_axis_tdata[31:0] !== e.hx || m_axis_tdata[63:32] !== e.hy ||
            m_axis_tuser[0] !== e.vert || m_axis_tuser[1] !== e.deg) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h v=%b d=%b got x=%h y=%h v=%b d=%b",
                     e.hx, e.hy, e.vert, e.deg, m_axis_tdata[31:0], m_axis_tdata[63:32],
                     m_axis_tuser[0], m_axis_tuser[1]);
        end
      end
    end
  end

  initial begin
    int k;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // directed corners
    pending_q.push_back(mk(0, 0, 65536, 65536, -655360, -655360, 655360, 655360));
    pending_q.push_back(mk(0, 0, -65536, 32768, -655360, -655360, 655360, 655360));
    pending_q.push_back(mk(0, 0, 65536, -131072, -655360, -655360, 655360, 655360));
    pending_q.push_back(mk(0, 0, -3, -1, -655360, -655360, 655360, 655360));
    pending_q.push_back(mk(5, 7, 5, 7, -100, -100, 100, 100));          // B equal to A
    pending_q.push_back(mk(0, 0, 0, 10, -100, -100, 100, 100));         // vertical ray
    pending_q.push_back(mk(0, 0, 10, 0, -100, -100, 100, 100));         // horizontal ray
    pending_q.push_back(mk(0, 0, 0, -10, -100, -100, 100, 100));
    pending_q.push_back(mk(0, 0, -10, 0, -100, -100, 100, 100));
    pending_q.push_back(mk(0, 0, 1, 1, -100, -100, 100, 100));          // cross zero
    pending_q.push_back(mk(0, 0, 1, 1000000, 0, 0, 32'h7fffffff, 1));   // steep ray, exits the top edge at x = 0
    pending_q.push_back(mk(0, 0, -1, 1000000, 32'h80000000, 0, 0, 1));
    pending_q.push_back(mk(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                           32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
    pending_q.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                           32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000));
    pending_q.push_back(mk(32'h7fffffff, 0, 32'h80000000, 1, 32'h7fffffff, 32'h80000000,
                           32'h80000000, 32'h7fffffff));
    pending_q.push_back(mk(10, 10, 20, 30, 100, 100, -100, -100));      // swapped corners
    pending_q.push_back(mk(500, 500, 510, 505, -100, -100, 100, 100));  // start outside
    pending_q.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1));
    while (pending_q.size() > 0) @(posedge clk);
    // sender pause until drained
    src_pause = 1'b1;
    while (exit_q.size() > 0 || s_axis_tvalid) @(posedge clk);
    src_pause = 1'b0;
    // receiver holds off while the sender keeps offering
    for (k = 0; k < 150; k++) pending_q.push_back(rnd_query());
    hold_off = 1'b1;
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
    // a stretch with no idling
    calm = 1'b1;
    for (k = 0; k < 200; k++) pending_q.push_back(rnd_query());
    while (pending_q.size() > 0) @(posedge clk);
    calm = 1'b0;
    for (k = 0; k < 500; k++) pending_q.push_back(rnd_query());
    while (pending_q.size() > 0 || (s_axis_tvalid && !s_axis_tready)) @(posedge clk);
    @(posedge clk);
    while (exit_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && exit_q.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ===== ray_rectangle_exit_point_core.f =====
rtl/rrep_pkg.sv
rtl/rrep_div_stage.sv
rtl/ray_rectangle_exit_point_core.sv
verif/tb_top.sv
